// File: src/htib_pkg.sv
// Package for the hash-to-id binding table: codes, entry type and defaults.
// No dependencies.
package htib_pkg;

  localparam int DEF_DEPTH = 64;
  localparam logic [7:0] RESERVED_NODE = 8'hFF;

  localparam logic [1:0] FN_SET  = 2'd0;
  localparam logic [1:0] FN_FIND = 2'd1;
  localparam logic [1:0] FN_AGE  = 2'd2;

  localparam logic [1:0] REG_CAP    = 2'd0;
  localparam logic [1:0] REG_EXPIRY = 2'd1;
  localparam logic [1:0] REG_NODE   = 2'd2;
  localparam logic [1:0] REG_HASH   = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_RESERVED = 3'd2;
  localparam logic [2:0] ST_CONFLICT = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_FOUND    = 3'd5;
  localparam logic [2:0] ST_MISS     = 3'd6;
  localparam logic [2:0] ST_AGED     = 3'd7;

  localparam int ENTRY_W = 75;

  typedef struct packed {
    logic [31:0] key_hash;
    logic [31:0] seen;
    logic [7:0]  node;
    logic [1:0]  origin;
    logic        conf;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_CMP_RD, S_CMP_CHK, S_APPEND, S_FIND_RD,
    S_FIND_CHK, S_DONE
  } state_t;

endpackage

// File: src/hash_to_id_binding_table_top.sv
// Hash-to-id binding table: entry RAM, scan sequencer and result register.
// Depends on htib_pkg and htib_ram.
// Set searches then compacts the entries (not on a conflict), find scans them, age compacts
// them if expiry is on; each entry takes a read then a check state on the single read port.
// Throughput: one word per operation; a new word is taken once the result is taken.
// Reset: synchronous active low; clears entry count, registers to defaults.
module hash_to_id_binding_table_top
  import htib_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[1:0], node[9:2], key_hash[41:10], origin_kind[43:42],
  // is_authoritative[44], now_ms[76:45], zero fill
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], found_node[10:3], found_authoritative[11], removed_count[18:12], zero fill
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [6:0]  cap_r;
  logic [31:0] expiry_r, own_hash_r;
  logic [7:0]  own_node_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0]  func_r;
  logic [7:0]  node_r;
  logic [31:0] hash_r, now_r;
  logic [1:0]  origin_r;
  logic        conf_r;
  logic [6:0]  removed_r, removed_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  fnode_r, fnode_nxt;
  logic        fconf_r, fconf_nxt;
  logic        upd_r, upd_nxt;
  logic        outv_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  htib_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rbits)
  );
  assign ram_rdata = entry_t'(ram_rbits);

  logic start;
  assign in_tready = (state_r == S_IDLE) && !outv_r;
  assign start = in_tvalid && in_tready;

  logic [CW-1:0] cap_eff;
  assign cap_eff = (int'(cap_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(cap_r);

  logic expired, drop;
  always_comb begin
    expired = 1'b0;
    if (!((ram_rdata.node == own_node_r) && (ram_rdata.key_hash == own_hash_r))
        && (expiry_r != 32'd0)) begin
      expired = (now_r - ram_rdata.seen) >= expiry_r;
    end
  end

  // compaction drop decision for the entry just read
  always_comb begin
    if (func_r == FN_AGE) begin
      drop = expired;
    end else begin
      drop = (ram_rdata.key_hash == hash_r) && (ram_rdata.node != node_r);
    end
  end

  entry_t new_e;
  assign new_e = '{key_hash: hash_r, seen: now_r, node: node_r, origin: origin_r,
                   conf: conf_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_tdata[1:0])
            FN_SET:  state_nxt = (in_tdata[9:2] == RESERVED_NODE) ? S_DONE : S_SRCH_RD;
            FN_FIND: state_nxt = S_FIND_RD;
            FN_AGE:  state_nxt = (expiry_r == 32'd0) ? S_DONE : S_CMP_RD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SRCH_RD:  state_nxt = (rd_r >= count_r) ? (upd_r ? S_CMP_RD : S_CMP_RD)
                                                : S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (ram_rdata.node == node_r) begin
          state_nxt = ((ram_rdata.key_hash != hash_r) && !conf_r) ? S_DONE : S_CMP_RD;
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_CMP_RD:   state_nxt = (rd_r >= count_r) ? ((func_r == FN_SET && !upd_r) ?
                                                   S_APPEND : S_DONE) : S_CMP_CHK;
      S_CMP_CHK:  state_nxt = S_CMP_RD;
      S_APPEND:   state_nxt = S_DONE;
      S_FIND_RD:  state_nxt = (rd_r >= count_r) ? S_DONE : S_FIND_CHK;
      S_FIND_CHK: state_nxt = ((ram_rdata.key_hash == hash_r) && !expired) ? S_DONE
                                                                           : S_FIND_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_nxt = rd_r;
    wr_nxt = wr_r;
    count_nxt = count_r;
    removed_nxt = removed_r;
    status_nxt = status_r;
    fnode_nxt = fnode_r;
    fconf_nxt = fconf_r;
    upd_nxt = upd_r;
    ram_we = 1'b0;
    ram_waddr = wr_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = rd_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          rd_nxt = '0;
          wr_nxt = '0;
          removed_nxt = '0;
          fnode_nxt = '0;
          fconf_nxt = 1'b0;
          upd_nxt = 1'b0;
          unique case (in_tdata[1:0])
            FN_SET:  status_nxt = (in_tdata[9:2] == RESERVED_NODE) ? ST_RESERVED : ST_ADDED;
            FN_FIND: status_nxt = ST_MISS;
            FN_AGE:  status_nxt = ST_AGED;
            default: status_nxt = ST_MISS;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (rd_r >= count_r) begin
          rd_nxt = '0;
        end else begin
          rd_nxt = rd_r + CW'(1);
        end
      end
      S_SRCH_CHK: begin
        if (ram_rdata.node == node_r) begin
          if ((ram_rdata.key_hash != hash_r) && !conf_r) begin
            status_nxt = ST_CONFLICT;
          end else begin
            ram_we = 1'b1;
            ram_waddr = AW'(rd_r - CW'(1));
            ram_wdata = new_e;
            upd_nxt = 1'b1;
            status_nxt = ST_UPDATED;
            rd_nxt = '0;
          end
        end
      end
      S_CMP_RD: begin
        if (rd_r >= count_r) begin
          count_nxt = wr_r;
          if (func_r == FN_SET && !upd_r && wr_r >= cap_eff) begin
            status_nxt = ST_FULL;
          end
        end else begin
          rd_nxt = rd_r + CW'(1);
        end
      end
      S_CMP_CHK: begin
        if (drop) begin
          removed_nxt = removed_r + 7'd1;
        end else begin
          ram_we = 1'b1;
          wr_nxt = wr_r + CW'(1);
        end
      end
      S_APPEND: begin
        if (count_r < cap_eff) begin
          ram_we = 1'b1;
          ram_waddr = count_r[AW-1:0];
          ram_wdata = new_e;
          count_nxt = count_r + CW'(1);
        end
      end
      S_FIND_RD: rd_nxt = rd_r + CW'(1);
      S_FIND_CHK: begin
        if ((ram_rdata.key_hash == hash_r) && !expired) begin
          status_nxt = ST_FOUND;
          fnode_nxt = ram_rdata.node;
          fconf_nxt = ram_rdata.conf;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      outv_r <= 1'b0;
      cap_r <= 7'd64;
      expiry_r <= '0;
      own_node_r <= '0;
      own_hash_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_DONE) begin
        outv_r <= 1'b1;
      end else if (out_tready) begin
        outv_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CAP:    cap_r <= cfg_wdata[6:0];
          REG_EXPIRY: expiry_r <= cfg_wdata;
          REG_NODE:   own_node_r <= cfg_wdata[7:0];
          REG_HASH:   own_hash_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
    wr_r <= wr_nxt;
    removed_r <= removed_nxt;
    status_r <= status_nxt;
    fnode_r <= fnode_nxt;
    fconf_r <= fconf_nxt;
    upd_r <= upd_nxt;
    if (start) begin
      func_r <= in_tdata[1:0];
      node_r <= in_tdata[9:2];
      hash_r <= in_tdata[41:10];
      origin_r <= in_tdata[43:42];
      conf_r <= in_tdata[44];
      now_r <= in_tdata[76:45];
    end
  end

  assign out_tvalid = outv_r;
  assign out_tdata = {5'd0, removed_r, fconf_r, fnode_r, status_r};

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("entry count beyond depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_tvalid) else $error("result not presented");
`endif
endmodule

// File: src/htib_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module htib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
